// ===== rtl/ilr_pkg.sv =====
// Shared types and constants for the isometric line rasterizer.
package ilr_pkg;

  localparam int FIELD_W = 12;   // width of the coordinate fields
  localparam int CRD_W   = 13;   // internal coordinate, holds any converted field
  localparam int DLT_W   = 13;   // absolute delta
  localparam int ERR_W   = 15;   // Bresenham error term
  localparam int SUM_W   = 15;   // projected column and row sum
  localparam int ROW_W   = 13;
  localparam int COLU_W  = 13;
  localparam int ADDR_W  = 19;
  localparam int COLOUR_W = 32;
  localparam int CFG_W   = 32;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;
  localparam int RES_CNT_W = $clog2(RES_DEPTH) + 1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic REG_VERTICAL_OFFSET = 1'b0;
  localparam logic REG_PIXEL_COLOUR    = 1'b1;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic                       action;
    logic signed [FIELD_W-1:0]  x_start;
    logic signed [FIELD_W-1:0]  y_start;
    logic signed [FIELD_W-1:0]  x_end;
    logic signed [FIELD_W-1:0]  y_end;
  } in_item_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [ADDR_W-1:0]    pixel_address;
    logic [COLOUR_W-1:0]  pixel_colour_out;
    logic                 line_done;
  } result_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vertical_offset;
    logic [COLOUR_W-1:0]       pixel_colour;
  } cfg_t;

  // Classified command passed from the front to the walker.
  typedef struct packed {
    logic                    is_start;
    crd_t                    x0;
    crd_t                    y0;
    crd_t                    x1;
    crd_t                    y1;
    logic [DLT_W-1:0]        dx;
    logic [DLT_W-1:0]        dy;
    logic                    sxn;
    logic                    syn;
    logic signed [ERR_W-1:0] err;
  } cmd_t;

endpackage

// ===== rtl/ilr_fifo.sv =====
// Small register-based first-in first-out queue.
module ilr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap on their own: depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ilr_front.sv =====
// Front end: convert endpoints and set up deltas, step signs and error term.
module ilr_front #(
  parameter int COORD_BITS = 12
) (
  input  ilr_pkg::in_item_t item,
  output ilr_pkg::cmd_t     cmd
);
  import ilr_pkg::*;

  // Take the low COORD_BITS bits of the field as two's complement.
  function automatic crd_t to_crd(input logic [FIELD_W-1:0] f);
    logic [COORD_BITS-1:0] t;
    t = COORD_BITS'(f);
    return CRD_W'(signed'(t));
  endfunction

  crd_t                    x0, y0, x1, y1;
  logic signed [CRD_W:0]   ddx, ddy;
  logic [DLT_W-1:0]        dx, dy;
  logic signed [ERR_W-1:0] half_dx, half_dy;

  always_comb begin
    x0  = to_crd(item.x_start);
    y0  = to_crd(item.y_start);
    x1  = to_crd(item.x_end);
    y1  = to_crd(item.y_end);
    ddx = (CRD_W+1)'(x1) - (CRD_W+1)'(x0);
    ddy = (CRD_W+1)'(y1) - (CRD_W+1)'(y0);
    dx  = (ddx < 0) ? DLT_W'(-ddx) : DLT_W'(ddx);
    dy  = (ddy < 0) ? DLT_W'(-ddy) : DLT_W'(ddy);
    // Deltas are never negative, so halving toward zero is a shift.
    half_dx = ERR_W'(dx >> 1);
    half_dy = ERR_W'(dy >> 1);

    cmd.is_start = (item.action == ACT_START);
    cmd.x0  = x0;
    cmd.y0  = y0;
    cmd.x1  = x1;
    cmd.y1  = y1;
    cmd.dx  = dx;
    cmd.dy  = dy;
    cmd.sxn = !(x0 < x1);
    cmd.syn = !(y0 < y1);
    cmd.err = (dx > dy) ? half_dx : -half_dy;
  end

endmodule

// ===== rtl/ilr_back.sv =====
// Back end: Bresenham walker, isometric projection and address stages.
module ilr_back #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ilr_pkg::cfg_t                      cfg,
  input  logic                               cmd_empty,
  input  ilr_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  input  logic [ilr_pkg::RES_CNT_W-1:0]      res_count,
  output logic                               res_push,
  output ilr_pkg::result_t                   res
);
  import ilr_pkg::*;

  localparam logic signed [SUM_W-1:0] COL_LIM = SUM_W'(IMAGE_WIDTH);
  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(2 * IMAGE_HEIGHT);

  // Walker state
  crd_t                    cur_x, cur_y, end_x, end_y;
  logic [DLT_W-1:0]        delta_x, delta_y;
  logic                    step_x_negative, step_y_negative;
  logic signed [ERR_W-1:0] error_term;
  logic                    finished;

  crd_t                    cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic [DLT_W-1:0]        delta_x_next, delta_y_next;
  logic                    step_x_negative_next, step_y_negative_next;
  logic signed [ERR_W-1:0] error_term_next;
  logic                    finished_next;

  logic                    fire;
  logic                    blank;
  logic signed [ERR_W:0]   e2, dxw, dyw, err_sum;
  logic                    move_x, move_y;

  // Stage flags: stage 1 is the walker state itself
  logic                    s1_valid, s1_blank;
  logic                    s2_valid, s2_vis, s2_done;
  logic [ROW_W-1:0]        s2_row;
  logic [COLU_W-1:0]       s2_col;

  logic signed [SUM_W-1:0] col, sum;
  logic                    vis;
  logic [RES_CNT_W+1:0]    in_flight;

  // Fire only when the result queue has room for everything already in flight.
  assign in_flight = (RES_CNT_W+2)'(res_count) + (RES_CNT_W+2)'(s1_valid)
                   + (RES_CNT_W+2)'(s2_valid);
  assign fire    = !cmd_empty && (in_flight < (RES_CNT_W+2)'(RES_DEPTH));
  assign cmd_pop = fire;
  assign blank   = !cmd.is_start && finished;

  always_comb begin
    cur_x_next           = cur_x;
    cur_y_next           = cur_y;
    end_x_next           = end_x;
    end_y_next           = end_y;
    delta_x_next         = delta_x;
    delta_y_next         = delta_y;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    error_term_next      = error_term;
    finished_next        = finished;

    e2      = (ERR_W+1)'(error_term);
    dxw     = (ERR_W+1)'(delta_x);
    dyw     = (ERR_W+1)'(delta_y);
    move_x  = (e2 > -dxw);
    move_y  = (e2 < dyw);
    err_sum = e2 - (move_x ? dyw : '0) + (move_y ? dxw : '0);

    if (fire) begin
      if (cmd.is_start) begin
        cur_x_next           = cmd.x0;
        cur_y_next           = cmd.y0;
        end_x_next           = cmd.x1;
        end_y_next           = cmd.y1;
        delta_x_next         = cmd.dx;
        delta_y_next         = cmd.dy;
        step_x_negative_next = cmd.sxn;
        step_y_negative_next = cmd.syn;
        error_term_next      = cmd.err;
        finished_next        = (cmd.x0 == cmd.x1) && (cmd.y0 == cmd.y1);
      end else if (!finished) begin
        if (move_x) begin
          cur_x_next = step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (move_y) begin
          cur_y_next = step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        error_term_next = ERR_W'(err_sum);
        finished_next   = (cur_x_next == end_x) && (cur_y_next == end_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      end_x           <= '0;
      end_y           <= '0;
      delta_x         <= '0;
      delta_y         <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      error_term      <= '0;
      finished        <= 1'b1;
      s1_valid        <= 1'b0;
      s1_blank        <= 1'b0;
      s2_valid        <= 1'b0;
    end else begin
      cur_x           <= cur_x_next;
      cur_y           <= cur_y_next;
      end_x           <= end_x_next;
      end_y           <= end_y_next;
      delta_x         <= delta_x_next;
      delta_y         <= delta_y_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      error_term      <= error_term_next;
      finished        <= finished_next;
      s1_valid        <= fire;
      s1_blank        <= fire && blank;
      s2_valid        <= s1_valid;
    end
  end

  // Project the point held by the walker.
  always_comb begin
    col = SUM_W'(cur_x) - SUM_W'(cur_y);
    sum = SUM_W'(cur_x) + SUM_W'(cur_y) - SUM_W'(cfg.vertical_offset);
    vis = !s1_blank && (col > 0) && (col < COL_LIM) && (sum > 0) && (sum < SUM_LIM);
  end

  always_ff @(posedge clk) begin
    s2_vis  <= vis;
    s2_done <= finished;
    s2_row  <= sum[ROW_W:1];
    s2_col  <= col[COLU_W-1:0];
  end

  assign res_push = s2_valid;

  always_comb begin
    res.pixel_valid      = s2_vis;
    res.pixel_address    = s2_vis ? ADDR_W'(ADDR_W'(s2_row) * ADDR_W'(IMAGE_WIDTH)
                                            + ADDR_W'(s2_col)) : '0;
    res.pixel_colour_out = s2_vis ? cfg.pixel_colour : '0;
    res.line_done        = s2_done;
  end

`ifndef ASSERT_OFF
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("projected point lost between stages");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_count < RES_CNT_W'(RES_DEPTH)))
    else $error("result pushed into a full queue");

  a_idle_step_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && blank) |=> ($stable(cur_x) && $stable(cur_y) && finished))
    else $error("step on a finished line moved the position");

  a_blank_is_done: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_blank) |-> finished)
    else $error("blank result without line finished");
`endif

endmodule

// ===== rtl/isometric_line_rasterizer_core.sv =====
// Top level of the isometric line rasterizer: queue ports, registers and pipeline.
//
// Walks a line with Bresenham's algorithm and projects each point isometrically
// (column = x - y, row = (x + y - vertical_offset) / 2). A start item (action 0)
// loads both endpoints and reports the first point; each step item (action 1)
// reports the next one. Every item gives exactly one result: pixel_valid,
// pixel_address (row * IMAGE_WIDTH + column, low 19 bits) and pixel_colour_out
// are set only when the point lies inside the window, and line_done marks the
// endpoint; a step after the end reports line_done alone. One item is taken
// per clock and one result leaves per clock while the result queue has room
// and results are popped. The walker updates position and error term once per
// cycle while step items are taken, and holds off while the four-entry result
// queue lacks room: while results are not popped, at most two more commands
// wait in the two-entry command queue before full rises. Write vertical_offset
// (index 0) and pixel_colour (index 1) only while no transaction is in flight.
module isometric_line_rasterizer_core #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 512,
  parameter int COORD_BITS   = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  ilr_pkg::in_item_t           item,
  input  logic                        pop,
  output logic                        empty,
  output ilr_pkg::result_t            result,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ilr_pkg::CFG_W-1:0]   cfg_data
);
  import ilr_pkg::*;

  cfg_t                  cfg;
  cmd_t                  cmd_in, cmd_out;
  logic                  cmd_empty, cmd_pop;
  logic [$clog2(CMD_DEPTH):0] cmd_count;
  logic                  res_push, res_full;
  result_t               res_in;
  logic [RES_CNT_W-1:0]  res_count;

  // Configuration registers: take a write whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERTICAL_OFFSET: cfg.vertical_offset <= cfg_data[FIELD_W-1:0];
        REG_PIXEL_COLOUR:    cfg.pixel_colour    <= cfg_data[COLOUR_W-1:0];
        default:             cfg <= cfg;
      endcase
    end
  end

  // Classify and set up each incoming transaction.
  ilr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .item (item),
    .cmd  (cmd_in)
  );

  // Command queue decouples the front from the walker.
  ilr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  // Walk, project and address; the back holds off while the result queue lacks room.
  ilr_back #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue: oldest result on the ports while empty is low.
  ilr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (res_count)
  );

`ifndef ASSERT_OFF
  a_cmd_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= ($clog2(CMD_DEPTH)+1)'(CMD_DEPTH))
    else $error("command queue count out of range");

  a_res_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!res_full || pop))
    else $error("result dropped at a full queue");

  a_pop_follows_push: assert property (@(posedge clk) disable iff (rst)
    (push && !full && cmd_empty) |=> !cmd_empty)
    else $error("accepted transaction missing from command queue");
`endif

endmodule
